FILE: rtl/stable_merge_sort_unit_defines.svh
// Assertion macros used by the sort unit's RTL.
`ifndef STABLE_MERGE_SORT_UNIT_DEFINES_SVH
`define STABLE_MERGE_SORT_UNIT_DEFINES_SVH

// Check that the consequent holds in the same cycle as the antecedent.
`define SSORT_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Check that the consequent holds in the cycle after the antecedent.
`define SSORT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/ssort_pkg.sv
package ssort_pkg;

  localparam int unsigned DATA_W = 32;

  // One incoming request: an element and the end-of-set mark.
  typedef struct packed {
    logic signed [DATA_W-1:0] value_in;
    logic                     last_in;
  } item_t;

  // One sorted result.
  typedef struct packed {
    logic signed [DATA_W-1:0] sorted_value;
    logic                     last_out;
    logic                     dropped_flag;
  } result_t;

endpackage

FILE: rtl/ssort_ram.sv
module ssort_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
  output logic [WIDTH-1:0]         rd_data_a,
  output logic [WIDTH-1:0]         rd_data_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write one word, read two words with registered output.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_a <= mem[rd_addr_a];
    rd_data_b <= mem[rd_addr_b];
  end

endmodule

FILE: rtl/stable_merge_sort_unit.sv
// Stable merge sort unit. Requests carry one signed 32-bit value each and are
// collected, one per cycle, into a store of DEPTH entries; values arriving
// when the store is full are dropped and every result of that set then has
// dropped_flag set. The request marked last starts a bottom-up merge sort
// (ties keep arrival order) that ping-pongs between two RAMs: one comparator
// handles one element at a time (RAM read, then compare and write), and
// a set of n elements needs ceil(log2 n) passes. Results then leave one at
// a time, each held until result_ready, the last one marked with last_out.
// The unit accepts no request from the last request of a set until its
// final result has been taken.
module stable_merge_sort_unit #(
  parameter int unsigned DEPTH = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               item_valid,
  output logic               item_ready,
  input  ssort_pkg::item_t   item,
  output logic               result_valid,
  input  logic               result_ready,
  output ssort_pkg::result_t result
);

`include "stable_merge_sort_unit_defines.svh"

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned DW = ssort_pkg::DATA_W;

  localparam logic [2:0] S_COLLECT = 3'd0;
  localparam logic [2:0] S_MRD     = 3'd1;
  localparam logic [2:0] S_MCMP    = 3'd2;
  localparam logic [2:0] S_ORD     = 3'd3;
  localparam logic [2:0] S_OLOAD   = 3'd4;
  localparam logic [2:0] S_OHOLD   = 3'd5;

  logic [2:0]    state, state_next;
  logic [CW-1:0] count, count_next;
  logic          overflow, overflow_next;
  logic [CW:0]   width, width_next;
  logic [CW-1:0] idx_i, idx_i_next;
  logic [CW-1:0] idx_j, idx_j_next;
  logic [CW-1:0] idx_k, idx_k_next;
  logic [CW-1:0] mid, mid_next;
  logic [CW-1:0] hi, hi_next;
  logic          src, src_next;
  logic          result_valid_next;
  ssort_pkg::result_t result_next;

  logic                 in_acc;
  logic                 has_room;
  logic                 take_left;
  logic signed [DW-1:0] rd_a, rd_b;
  logic [DW-1:0]        r0_a, r0_b, r1_a, r1_b;
  logic [DW-1:0]        merged;
  logic [CW+1:0]        sum_mid, sum_hi;
  logic [CW:0]          w2;

  logic          r0_we, r1_we;
  logic [AW-1:0] r0_waddr;
  logic [DW-1:0] r0_wdata;
  logic [AW-1:0] rd_addr_a, rd_addr_b;

  assign item_ready = (state == S_COLLECT);
  assign in_acc     = item_valid && item_ready;
  assign has_room   = (count < CW'(DEPTH));

  // Select the source run data.
  assign rd_a = src ? $signed(r1_a) : $signed(r0_a);
  assign rd_b = src ? $signed(r1_b) : $signed(r0_b);

  // Compare: the left run wins on equal values.
  assign take_left = (idx_i < mid) && ((idx_j >= hi) || (rd_a <= rd_b));
  assign merged    = take_left ? rd_a : rd_b;

  assign rd_addr_a = (state == S_MRD) ? idx_i[AW-1:0] : idx_k[AW-1:0];
  assign rd_addr_b = idx_j[AW-1:0];

  // Route writes: collection and passes that read RAM 1 go to RAM 0.
  assign r0_we    = (in_acc && has_room) || ((state == S_MCMP) && src);
  assign r0_waddr = (state == S_COLLECT) ? count[AW-1:0] : idx_k[AW-1:0];
  assign r0_wdata = (state == S_COLLECT) ? item.value_in : merged;
  assign r1_we    = (state == S_MCMP) && !src;

  ssort_ram #(.WIDTH(DW), .DEPTH(DEPTH)) u_ram0 (
    .clk       (clk),
    .wr_en     (r0_we),
    .wr_addr   (r0_waddr),
    .wr_data   (r0_wdata),
    .rd_addr_a (rd_addr_a),
    .rd_addr_b (rd_addr_b),
    .rd_data_a (r0_a),
    .rd_data_b (r0_b)
  );

  ssort_ram #(.WIDTH(DW), .DEPTH(DEPTH)) u_ram1 (
    .clk       (clk),
    .wr_en     (r1_we),
    .wr_addr   (idx_k[AW-1:0]),
    .wr_data   (merged),
    .rd_addr_a (rd_addr_a),
    .rd_addr_b (rd_addr_b),
    .rd_data_a (r1_a),
    .rd_data_b (r1_b)
  );

  // Sequence collection, merge passes and emission.
  always_comb begin
    state_next        = state;
    count_next        = count;
    overflow_next     = overflow;
    width_next        = width;
    idx_i_next        = idx_i;
    idx_j_next        = idx_j;
    idx_k_next        = idx_k;
    mid_next          = mid;
    hi_next           = hi;
    src_next          = src;
    result_valid_next = result_valid;
    result_next       = result;
    sum_mid           = '0;
    sum_hi            = '0;
    w2                = '0;
    unique case (state)
      S_COLLECT: begin
        if (in_acc) begin
          if (has_room) begin
            count_next = count + CW'(1);
          end else begin
            overflow_next = 1'b1;
          end
          if (item.last_in) begin
            src_next   = 1'b0;
            idx_k_next = '0;
            if (count_next > CW'(1)) begin
              width_next = (CW+1)'(1);
              idx_i_next = '0;
              mid_next   = CW'(1);
              idx_j_next = CW'(1);
              hi_next    = CW'(2);
              state_next = S_MRD;
            end else begin
              state_next = S_ORD;
            end
          end
        end
      end
      S_MRD: begin
        state_next = S_MCMP;
      end
      S_MCMP: begin
        idx_k_next = idx_k + CW'(1);
        if (take_left) begin
          idx_i_next = idx_i + CW'(1);
        end else begin
          idx_j_next = idx_j + CW'(1);
        end
        state_next = S_MRD;
        if (idx_k_next == hi) begin
          if (hi == count) begin
            // Close the pass: double the run width and swap RAMs.
            w2         = width << 1;
            width_next = w2;
            src_next   = !src;
            idx_k_next = '0;
            if (w2 >= (CW+1)'(count)) begin
              state_next = S_ORD;
            end else begin
              sum_mid    = (CW+2)'(w2);
              sum_hi     = (CW+2)'(w2) << 1;
              idx_i_next = '0;
              mid_next   = (sum_mid > (CW+2)'(count)) ? count : sum_mid[CW-1:0];
              idx_j_next = mid_next;
              hi_next    = (sum_hi > (CW+2)'(count)) ? count : sum_hi[CW-1:0];
            end
          end else begin
            // Open the next pair of runs.
            sum_mid    = (CW+2)'(hi) + (CW+2)'(width);
            sum_hi     = sum_mid + (CW+2)'(width);
            idx_i_next = hi;
            mid_next   = (sum_mid > (CW+2)'(count)) ? count : sum_mid[CW-1:0];
            idx_j_next = mid_next;
            hi_next    = (sum_hi > (CW+2)'(count)) ? count : sum_hi[CW-1:0];
          end
        end
      end
      S_ORD: begin
        state_next = S_OLOAD;
      end
      S_OLOAD: begin
        result_next.sorted_value = rd_a;
        result_next.last_out     = (idx_k + CW'(1) == count);
        result_next.dropped_flag = overflow;
        result_valid_next        = 1'b1;
        state_next               = S_OHOLD;
      end
      S_OHOLD: begin
        if (result_ready) begin
          result_valid_next = 1'b0;
          if (result.last_out) begin
            count_next    = '0;
            overflow_next = 1'b0;
            state_next    = S_COLLECT;
          end else begin
            idx_k_next = idx_k + CW'(1);
            state_next = S_ORD;
          end
        end
      end
      default: begin
        state_next = S_COLLECT;
      end
    endcase
  end

  // Hold control state under reset, advance otherwise.
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_COLLECT;
      count        <= '0;
      overflow     <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      state        <= state_next;
      count        <= count_next;
      overflow     <= overflow_next;
      result_valid <= result_valid_next;
    end
  end

  // Merge indices and result payload.
  always_ff @(posedge clk) begin
    width  <= width_next;
    idx_i  <= idx_i_next;
    idx_j  <= idx_j_next;
    idx_k  <= idx_k_next;
    mid    <= mid_next;
    hi     <= hi_next;
    src    <= src_next;
    result <= result_next;
  end

  `SSORT_ASSERT_SAME(a_ready_excl, item_ready, !result_valid, "request taken while result pending")
  `SSORT_ASSERT_SAME(a_count_bound, 1'b1, count <= CW'(DEPTH), "element count above depth")
  `SSORT_ASSERT_NEXT(a_back_to_collect, result_valid && result_ready && result.last_out, item_ready, "no return to collection after final result")
  `SSORT_ASSERT_SAME(a_merge_bound, state == S_MCMP, idx_k < count && hi <= count, "merge index beyond set")

endmodule

FILE: tb/stable_merge_sort_unit_test.sv
`timescale 1ns / 1ps

module stable_merge_sort_unit_test;

  localparam int unsigned SET_DEPTH = 16;
  localparam int TOTAL_REQUESTS = 460;
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int SETTLE_CYCLES = 60;
  localparam int REPORT_LIMIT = 10;

  localparam logic signed [ssort_pkg::DATA_W-1:0] VAL_MIN = 32'sh8000_0000;
  localparam logic signed [ssort_pkg::DATA_W-1:0] VAL_MAX = 32'sh7FFF_FFFF;

  typedef enum int {STYLE_WIDE, STYLE_TIES, STYLE_EDGES, STYLE_MIXED} value_style_t;

  // One directed row: the request, and the result typed in where it is obvious
  typedef struct packed {
    ssort_pkg::item_t   req;
    logic               typed;
    ssort_pkg::result_t want;
  } stim_row_t;

  localparam int DIRECTED_COUNT = 23;
  localparam stim_row_t DIRECTED_ROWS [0:DIRECTED_COUNT-1] = '{
    // single-element sets straight after reset, at the extremes
    '{'{VAL_MIN, 1'b1}, 1'b1, '{VAL_MIN, 1'b1, 1'b0}},
    '{'{VAL_MAX, 1'b1}, 1'b1, '{VAL_MAX, 1'b1, 1'b0}},
    // short set with a tie
    '{'{32'sd5, 1'b0}, 1'b0, '0},
    '{'{-32'sd5, 1'b0}, 1'b0, '0},
    '{'{32'sd5, 1'b1}, 1'b0, '0},
    // fill the store exactly, then overflow it, the marked request dropped too
    '{'{32'sd7, 1'b0}, 1'b0, '0},
    '{'{-32'sd7, 1'b0}, 1'b0, '0},
    '{'{32'sd7, 1'b0}, 1'b0, '0},
    '{'{32'sd0, 1'b0}, 1'b0, '0},
    '{'{VAL_MAX, 1'b0}, 1'b0, '0},
    '{'{VAL_MIN, 1'b0}, 1'b0, '0},
    '{'{32'sd100, 1'b0}, 1'b0, '0},
    '{'{-32'sd100, 1'b0}, 1'b0, '0},
    '{'{32'sd7, 1'b0}, 1'b0, '0},
    '{'{32'sd1, 1'b0}, 1'b0, '0},
    '{'{-32'sd1, 1'b0}, 1'b0, '0},
    '{'{32'sd0, 1'b0}, 1'b0, '0},
    '{'{32'sd42, 1'b0}, 1'b0, '0},
    '{'{32'sd3, 1'b0}, 1'b0, '0},
    '{'{-32'sd3, 1'b0}, 1'b0, '0},
    '{'{32'sd7, 1'b0}, 1'b0, '0},
    '{'{32'sd9, 1'b0}, 1'b0, '0},
    '{'{VAL_MIN, 1'b1}, 1'b0, '0}
  };

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               item_valid = 1'b0;
  logic               item_ready;
  ssort_pkg::item_t   item = '0;
  logic               result_valid;
  logic               result_ready = 1'b0;
  ssort_pkg::result_t result;

  // Predictor state: values held for the current set, and whether any was dropped
  logic signed [ssort_pkg::DATA_W-1:0] collected_values[$];
  logic                                set_dropped = 1'b0;
  ssort_pkg::result_t                  expected_sorted[$];

  bit burst_phase = 1'b0;
  bit hold_off_pending = 1'b0;

  int requests_sent = 0;
  int sets_closed = 0;
  int overflow_sets = 0;
  int results_checked = 0;
  int mismatches = 0;
  int hold_offs_done = 0;
  int drain_pauses = 0;

  stable_merge_sort_unit #(
    .DEPTH(SET_DEPTH)
  ) u_top (
    .clk(clk),
    .rst(rst),
    .item_valid(item_valid),
    .item_ready(item_ready),
    .item(item),
    .result_valid(result_valid),
    .result_ready(result_ready),
    .result(result)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Absorb one accepted request; on a marked one, produce the sorted set
  function automatic void predict_sorted_set(input ssort_pkg::item_t req,
                                             output ssort_pkg::result_t produced[$]);
    logic signed [ssort_pkg::DATA_W-1:0] ordered[$];
    logic signed [ssort_pkg::DATA_W-1:0] pick;
    int i;
    int j;
    produced = {};
    if (collected_values.size() < SET_DEPTH) collected_values.push_back(req.value_in);
    else set_dropped = 1'b1;
    if (req.last_in) begin
      ordered = collected_values;
      // insertion sort; move past strictly greater only, so ties keep arrival order
      for (i = 1; i < ordered.size(); i++) begin
        pick = ordered[i];
        j = i;
        while (j > 0 && ordered[j-1] > pick) begin
          ordered[j] = ordered[j-1];
          j--;
        end
        ordered[j] = pick;
      end
      for (i = 0; i < ordered.size(); i++) begin
        produced.push_back('{ordered[i], (i == ordered.size() - 1), set_dropped});
      end
      sets_closed++;
      if (set_dropped) overflow_sets++;
      collected_values = {};
      set_dropped = 1'b0;
    end
  endfunction

  // Mostly short idle stretches, now and then a long one
  function automatic int idle_length();
    if ($urandom_range(0, 99) < 85) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic signed [ssort_pkg::DATA_W-1:0] element_value(
      input value_style_t style);
    value_style_t chosen;
    int offset;
    chosen = style;
    if (style == STYLE_MIXED) chosen = value_style_t'($urandom_range(0, 2));
    case (chosen)
      STYLE_WIDE: return $urandom;
      STYLE_TIES: begin
        offset = $urandom_range(0, 6);
        return offset - 3;
      end
      default: begin
        case ($urandom_range(0, 4))
          0: return VAL_MIN;
          1: return VAL_MAX;
          2: return 0;
          3: return -1;
          default: return 1;
        endcase
      end
    endcase
  endfunction

  // Offer one request and hold it until taken; called at a falling edge
  task automatic offer_request(input ssort_pkg::item_t req, input bit typed,
                               input ssort_pkg::result_t want, input bit no_gap);
    ssort_pkg::result_t produced[$];
    int gap;
    item <= req;
    item_valid <= 1'b1;
    @(posedge clk);
    while (item_ready !== 1'b1) @(posedge clk);
    predict_sorted_set(req, produced);
    if (typed) expected_sorted.push_back(want);
    else foreach (produced[k]) expected_sorted.push_back(produced[k]);
    requests_sent++;
    @(negedge clk);
    if (!no_gap && $urandom_range(0, 2) == 0) begin
      gap = idle_length();
      item_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  // Drop valid and wait until every expected result has been taken
  task automatic await_drain();
    item_valid <= 1'b0;
    while (expected_sorted.size() != 0) @(posedge clk);
    @(negedge clk);
    drain_pauses++;
  endtask

  initial begin : stimulus
    int row_idx;
    int elem;
    int set_size;
    int set_idx;
    bit burst;
    value_style_t style;
    ssort_pkg::item_t req;

    repeat (8) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // walk the directed table
    for (row_idx = 0; row_idx < DIRECTED_COUNT; row_idx++) begin
      offer_request(DIRECTED_ROWS[row_idx].req, DIRECTED_ROWS[row_idx].typed,
                    DIRECTED_ROWS[row_idx].want, 1'b0);
    end
    await_drain();

    // random sets, mostly within the store, some overflowing it
    set_idx = 0;
    while (requests_sent < TOTAL_REQUESTS) begin
      case ($urandom_range(0, 9))
        0: set_size = SET_DEPTH;
        1: set_size = $urandom_range(SET_DEPTH + 1, SET_DEPTH + 4);
        default: set_size = $urandom_range(1, SET_DEPTH - 1);
      endcase
      style = value_style_t'($urandom_range(0, 3));
      burst = ($urandom_range(0, 4) == 0);
      if (set_idx % 9 == 4) await_drain();
      if (set_idx == 3 || set_idx == 17) hold_off_pending = 1'b1;
      burst_phase = burst;
      for (elem = 0; elem < set_size; elem++) begin
        req.value_in = element_value(style);
        req.last_in = (elem == set_size - 1);
        offer_request(req, 1'b0, '0, burst);
      end
      set_idx++;
    end
    burst_phase = 1'b0;

    // wait out the remaining results, then give stray ones a chance to show
    await_drain();
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("Sent %0d requests in %0d sets (%0d overflowed the store); checked %0d results.",
             requests_sent, sets_closed, overflow_sets, results_checked);
    $display("Receiver held off %0d times; sender paused for a full drain %0d times.",
             hold_offs_done, drain_pauses);
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("%0d result mismatches.", mismatches);
      $display("== FAIL ==");
    end
    $finish;
  end

  // Drive result_ready: random gaps, a long hold-off on demand, none in burst phases
  initial begin : result_sink
    int gap;
    while (rst) @(negedge clk);
    forever begin
      if (hold_off_pending) begin
        hold_off_pending = 1'b0;
        result_ready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(negedge clk);
        hold_offs_done++;
      end else if (!burst_phase && $urandom_range(0, 3) == 0) begin
        gap = idle_length();
        result_ready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      result_ready <= 1'b1;
      @(negedge clk);
    end
  end

  // Compare each taken result with the oldest expectation
  always @(posedge clk) begin : result_check
    ssort_pkg::result_t want;
    if (!rst && result_valid === 1'b1 && result_ready === 1'b1) begin
      if (expected_sorted.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
          $display("Unexpected result: value %0d last %b dropped %b", result.sorted_value,
                   result.last_out, result.dropped_flag);
      end else begin
        want = expected_sorted.pop_front();
        results_checked++;
        if (result.sorted_value !== want.sorted_value || result.last_out !== want.last_out ||
            result.dropped_flag !== want.dropped_flag) begin
          mismatches++;
          if (mismatches <= REPORT_LIMIT)
            $display("Result %0d mismatch: expected value %0d last %b dropped %b, got %0d %b %b",
                     results_checked, want.sorted_value, want.last_out, want.dropped_flag,
                     result.sorted_value, result.last_out, result.dropped_flag);
        end
      end
    end
  end

  // Hard limit on the run
  initial begin : run_limit
    #4_000_000;
    $display("Run limit reached with %0d results outstanding.", expected_sorted.size());
    $display("== FAIL ==");
    $finish;
  end

endmodule

FILE: stable_merge_sort_unit.f
+incdir+rtl
rtl/ssort_pkg.sv
rtl/ssort_ram.sv
rtl/stable_merge_sort_unit.sv
tb/stable_merge_sort_unit_test.sv
